// ===== design/rtc_pkg.sv =====
// Shared types and constants for the RGB to CMYK converter.
// Holds the reciprocal table used by the ink lanes; depends on nothing.
package rtc_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumW   = 17;  // 510*(mx-ch)+mx, at most 130305
  localparam int unsigned RecipK = 27;  // reciprocal scale: 2^27
  localparam int unsigned RecipW = 27;  // ceil(2^27/(2*mx)), at most 2^26
  localparam int unsigned ProdW  = NumW + RecipW;

  typedef logic [RecipW-1:0] recip_t;
  typedef recip_t recip_tab_t [256];

  // Per-stage advance enables handed to each ink lane
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // ceil(2^27 / (2*mx)) for every mx, built by restoring division at elaboration.
  // Entry 0 is unused (black pixel is forced in the output stage).
  function automatic recip_tab_t build_recip();
    recip_tab_t  tab;
    logic [27:0] num;
    logic [9:0]  den;
    logic [9:0]  rem;
    logic [27:0] quo;
    for (int i = 0; i < 256; i++) begin
      den = 10'(2 * i);
      if (i == 0) begin
        tab[i] = '0;
      end else begin
        num = 28'((1 << RecipK) + 2 * i - 1);
        rem = '0;
        quo = '0;
        for (int b = 27; b >= 0; b--) begin
          rem = {rem[8:0], num[b]};
          if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
          end
        end
        tab[i] = quo[RecipW-1:0];
      end
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

// ===== design/rtc_ink_lane.sv =====
// One ink channel: numerator, reciprocal multiply and quotient select.
// Uses rtc_pkg for widths and the stage enable struct.
module rtc_ink_lane (
  input  logic                         clk_i,
  input  rtc_pkg::stage_en_t           en_i,
  input  logic [rtc_pkg::ChanW-1:0]    ch_i,     // stage 1 channel value
  input  logic [rtc_pkg::ChanW-1:0]    mx_i,     // stage 1 largest channel
  input  rtc_pkg::recip_t              recip_i,  // stage 2 reciprocal of 2*mx
  output logic [rtc_pkg::ChanW-1:0]    ink_o     // stage 4 ink value
);

  logic [rtc_pkg::ChanW-1:0] diff;
  logic [rtc_pkg::NumW-1:0]  num_d, num_q;
  logic [rtc_pkg::ProdW-1:0] prod_d, prod_q;
  logic [rtc_pkg::ChanW-1:0] ink_d, ink_q;

  // Stage 2: numerator 510*(mx-ch)+mx, ch never exceeds mx
  assign diff  = mx_i - ch_i;
  assign num_d = {diff, 9'b0} - {8'b0, diff, 1'b0} + {9'b0, mx_i};

  // Stage 3: scaled quotient
  assign prod_d = rtc_pkg::ProdW'(num_q) * rtc_pkg::ProdW'(recip_i);

  // Stage 4: quotient always fits in eight bits
  assign ink_d = prod_q[rtc_pkg::RecipK +: rtc_pkg::ChanW];

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      num_q <= num_d;
    end
    if (en_i.s3) begin
      prod_q <= prod_d;
    end
    if (en_i.s4) begin
      ink_q <= ink_d;
    end
  end

  assign ink_o = ink_q;

endmodule

// ===== design/rgb_to_cmyk_converter.sv =====
// RGB to CMYK converter: four-stage pipeline, one pixel per clock sustained while
// the output is not stalled; each stage holds its item independently, so bubbles
// are squeezed out under stall.
// Stages: channel maximum, reciprocal lookup, multiply, quotient select.
// Reset (rst_ni low, asynchronous) empties all stages; no clearing pass.
// Depends on rtc_pkg and rtc_ink_lane.
module rgb_to_cmyk_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // rgb_pixel: blue 7:0, green 15:8, red 23:16
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // cyan 7:0, magenta 15:8, yellow 23:16, black 31:24
);

  localparam int unsigned W = rtc_pkg::ChanW;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  rtc_pkg::stage_en_t lane_en;

  logic [W-1:0] red, green, blue, mx_d;
  logic [W-1:0] r1_q, g1_q, b1_q, mx1_q;
  rtc_pkg::recip_t recip2_q;
  logic [W-1:0] black2_q, black3_q, black4_q;
  logic zero2_q, zero3_q, zero4_q;
  logic [W-1:0] cyan, magenta, yellow;

  // Per-stage advance: a stage moves when empty or when its successor moves
  assign en4 = ~v4_q | m_axis_tready;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign s_axis_tready = en1;
  assign lane_en = '{s2: en2, s3: en3, s4: en4};

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: largest channel
  assign red   = s_axis_tdata[23:16];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[7:0];

  always_comb begin
    mx_d = red;
    if (green > mx_d) mx_d = green;
    if (blue > mx_d) mx_d = blue;
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (en1) begin
      r1_q  <= red;
      g1_q  <= green;
      b1_q  <= blue;
      mx1_q <= mx_d;
    end
    // Stage 2: reciprocal lookup, black and the all-dark flag
    if (en2) begin
      recip2_q <= rtc_pkg::RECIP_TAB[mx1_q];
      black2_q <= 8'hFF - mx1_q;
      zero2_q  <= (mx1_q == '0);
    end
    if (en3) begin
      black3_q <= black2_q;
      zero3_q  <= zero2_q;
    end
    if (en4) begin
      black4_q <= black3_q;
      zero4_q  <= zero3_q;
    end
  end

  // Ink lanes
  rtc_ink_lane u_cyan (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .ch_i    (r1_q),
    .mx_i    (mx1_q),
    .recip_i (recip2_q),
    .ink_o   (cyan)
  );

  rtc_ink_lane u_magenta (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .ch_i    (g1_q),
    .mx_i    (mx1_q),
    .recip_i (recip2_q),
    .ink_o   (magenta)
  );

  rtc_ink_lane u_yellow (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .ch_i    (b1_q),
    .mx_i    (mx1_q),
    .recip_i (recip2_q),
    .ink_o   (yellow)
  );

  // Output: a fully dark pixel carries no ink
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = zero4_q ? {black4_q, 24'h0} : {black4_q, yellow, magenta, cyan};

`ifndef ASSERT_OFF
  // An empty first stage always takes a transfer
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("input not ready with first stage empty");

  // A full pipeline with a stalled output must refuse input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while pipeline full and stalled");

  // Stage 1 maximum is one of the channels and no channel exceeds it
  a_max_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (mx1_q >= r1_q && mx1_q >= g1_q && mx1_q >= b1_q &&
              (mx1_q == r1_q || mx1_q == g1_q || mx1_q == b1_q)))
    else $error("stage 1 maximum wrong");

  // A held item in stage 2 stays valid
  a_hold_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> v2_q)
    else $error("stage 2 item lost under stall");
`endif

endmodule
